// File: hw/rtl/cerq_pkg.sv
// cerq_pkg: shared types and codes for the coalescing event ring queue.
// Transaction structs, mode/status/register codes, entry memory word layout.
// No dependencies.
`timescale 1ns / 1ps

package cerq_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int NUM_REGS   = 6;

	localparam logic [CFG_IDX_W-1:0] REG_MOUSE_MOVE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_DOWN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_UP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_DOWN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_LEFT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ARROW_RIGHT = 3'd5;

	// request modes
	localparam logic [1:0] MODE_POST_EVENT = 2'd0;
	localparam logic [1:0] MODE_POST_RAW   = 2'd1;
	localparam logic [1:0] MODE_GET_HEAD   = 2'd2;
	localparam logic [1:0] MODE_GET_INDEX  = 2'd3;

	// result status
	localparam logic [2:0] STAT_APPENDED  = 3'd0;
	localparam logic [2:0] STAT_MERGED    = 3'd1;
	localparam logic [2:0] STAT_REJECTED  = 3'd2;
	localparam logic [2:0] STAT_DELIVERED = 3'd3;
	localparam logic [2:0] STAT_NONE      = 3'd4;

	localparam int CODE_W = 31;

	typedef struct packed {
		logic [1:0]         mode;
		logic [3:0]         queue_id;
		logic [15:0]        sender;
		logic signed [31:0] code;
		logic [63:0]        word1;
		logic [63:0]        word2;
		logic [63:0]        word3;
		logic [63:0]        word4;
		logic [63:0]        now;
		logic [4:0]         read_index;
		logic               restart;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [CODE_W-1:0] out_code;
		logic [63:0]       out_word1;
		logic [63:0]       out_word2;
		logic [63:0]       out_word3;
		logic [63:0]       out_word4;
		logic [15:0]       out_sender;
		logic [3:0]        out_queue;
		logic [63:0]       read_time;
	} result_t;

	// payload part of one ring entry (code is kept in its own memory)
	typedef struct packed {
		logic [15:0] sender;
		logic [63:0] word1;
		logic [63:0] word2;
		logic [63:0] word3;
		logic [63:0] word4;
	} entry_data_t;

	typedef struct packed {
		logic code_we;
		logic data_we;
	} mem_wr_t;

endpackage

// File: hw/rtl/cerq_entry_mem.sv
// cerq_entry_mem: ring entry storage, code memory plus payload memory.
// Registered read; code memory swept to zero after reset.
// Depends on cerq_pkg.
`timescale 1ns / 1ps

module cerq_entry_mem import cerq_pkg::*; #(
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [CODE_W-1:0]        rd_code,
	output entry_data_t              rd_data,
	input  mem_wr_t                  wr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [CODE_W-1:0]        wr_code,
	input  entry_data_t              wr_data,
	output logic                     busy
);

	localparam int AW = $clog2(DEPTH);

	logic [CODE_W-1:0] code_mem [DEPTH];
	entry_data_t       data_mem [DEPTH];

	logic          busy_q;
	logic [AW-1:0] clr_addr_q;

	logic              code_we;
	logic [AW-1:0]     code_addr;
	logic [CODE_W-1:0] code_din;

	// clear sweep owns the code write port until done
	always_comb begin
		if (busy_q) begin
			code_we   = 1'b1;
			code_addr = clr_addr_q;
			code_din  = '0;
		end else begin
			code_we   = wr.code_we;
			code_addr = wr_addr;
			code_din  = wr_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DEPTH - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (code_we)
			code_mem[code_addr] <= code_din;
		if (rd_en)
			rd_code <= code_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.data_we && !busy_q)
			data_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= data_mem[rd_addr];
	end

	assign busy = busy_q;

endmodule

// File: hw/rtl/cerq_ptr_file.sv
// cerq_ptr_file: head and tail slot of every ring.
// Asynchronously reset to zero; one read port, one write port.
// Depends on cerq_pkg.
`timescale 1ns / 1ps

module cerq_ptr_file import cerq_pkg::*; #(
	parameter int NUM_QUEUES = 16,
	parameter int SLOT_W     = 5,
	parameter int QW         = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [QW-1:0]     rd_q,
	output logic [SLOT_W-1:0] rd_head,
	output logic [SLOT_W-1:0] rd_tail,
	input  logic              we,
	input  logic [QW-1:0]     wr_q,
	input  logic [SLOT_W-1:0] wr_head,
	input  logic [SLOT_W-1:0] wr_tail
);

	logic [SLOT_W-1:0] head_q [NUM_QUEUES];
	logic [SLOT_W-1:0] tail_q [NUM_QUEUES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (we) begin
			head_q[wr_q] <= wr_head;
			tail_q[wr_q] <= wr_tail;
		end
	end

	assign rd_head = head_q[rd_q];
	assign rd_tail = tail_q[rd_q];

endmodule

// File: hw/rtl/coalescing_event_ring_queue_core.sv
// coalescing_event_ring_queue_core: top level of the coalescing message ring queue.
// Holds config registers, sequencer and read-modify-write datapath.
// Depends on cerq_pkg, cerq_entry_mem, cerq_ptr_file.
`timescale 1ns / 1ps

//  channel  | signals                           | role
//  ---------+-----------------------------------+------------------------------------
//  item     | item_valid, item_ready, item      | request transaction (post / get)
//  result   | result_valid, result_ready, result| one status transaction per request
//  cfg      | cfg_wr_en, cfg_index, cfg_data    | register write, no wait, no read-back
//
// Per request, the accept edge launches the registered entry memory read and
// moves to EXEC; the next edge writes back the entry, updates the ring
// pointers and loads the result register. No request is taken while in EXEC.
// After reset the code memory is swept to zero over all NUM_QUEUES*QUEUE_DEPTH entries
// (512 at defaults); item_ready stays low meanwhile, cfg writes are taken.
// item_ready also drops while a result waits and result_ready is low.

module coalescing_event_ring_queue_core import cerq_pkg::*; #(
	parameter int NUM_QUEUES  = 16,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result
);

	localparam int N_ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW        = $clog2(N_ENTRIES);
	localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
	localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	function automatic logic [AW-1:0] entry_addr(input logic [QW-1:0] q,
	                                             input logic [SLOT_W-1:0] s);
		return AW'(int'(q) * QUEUE_DEPTH + int'(s));
	endfunction

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : s - 1'b1;
	endfunction

	// ---------------- configuration registers ----------------
	logic [CFG_DATA_W-1:0] cfg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_q[i] <= '0;
		end else if (cfg_wr_en && (int'(cfg_index) < NUM_REGS)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// ---------------- sequencer ----------------
	logic [1:0] state_q;
	logic       result_valid_q;
	logic       accept;
	logic       exec;
	logic       clr_busy;

	assign item_ready   = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
	assign accept       = item_valid && item_ready;
	assign exec         = (state_q == ST_EXEC);
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: if (!clr_busy) state_q <= ST_IDLE;
				ST_IDLE:  if (accept) state_q <= ST_EXEC;
				ST_EXEC:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- accept side: pointer lookup and read launch ----------------
	logic [QW-1:0]     q_idx;
	logic              q_ok;
	logic [SLOT_W-1:0] ptr_head, ptr_tail;
	logic [SLOT_W-1:0] rd_slot;
	logic [AW-1:0]     rd_addr;

	// pointers are only touched in EXEC, so one read port serves both stages
	logic [QW-1:0] ptr_rd_q;
	assign q_idx    = QW'(item.queue_id);
	assign q_ok     = int'(item.queue_id) < NUM_QUEUES;
	assign ptr_rd_q = q_idx;

	always_comb begin
		case (item.mode)
			MODE_POST_EVENT: rd_slot = prev_slot(ptr_tail);   // last entry, merge target
			MODE_GET_HEAD:   rd_slot = ptr_head;
			MODE_GET_INDEX:  rd_slot = SLOT_W'(item.read_index);
			default:         rd_slot = ptr_tail;
		endcase
	end

	assign rd_addr = entry_addr(q_idx, rd_slot);

	// stage 1 registers, captured at accept
	item_t             item_s1;
	logic              q_ok_s1;
	logic [AW-1:0]     rd_addr_s1;
	logic [SLOT_W-1:0] head_s1, tail_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item;
			q_ok_s1    <= q_ok;
			rd_addr_s1 <= rd_addr;
			head_s1    <= ptr_head;
			tail_s1    <= ptr_tail;
		end
	end

	// ---------------- execute: modify and write back ----------------
	logic [CODE_W-1:0] rd_code;
	entry_data_t       rd_data;

	logic [CODE_W-1:0] code31;
	logic              code_neg;
	logic              same;
	logic              is_mouse, is_key, is_arrow;
	logic              idx_ok;
	logic [QW-1:0]     q_s1_idx;
	logic [AW-1:0]     tail_addr;

	assign code31    = item_s1.code[CODE_W-1:0];
	assign code_neg  = item_s1.code[31];
	assign same      = (rd_code == code31);
	assign is_mouse  = (code31 == cfg_q[REG_MOUSE_MOVE]);
	assign is_key    = (code31 == cfg_q[REG_KEY_DOWN]);
	assign is_arrow  = (code31 == cfg_q[REG_ARROW_UP])   || (code31 == cfg_q[REG_ARROW_DOWN]) ||
	                   (code31 == cfg_q[REG_ARROW_LEFT]) || (code31 == cfg_q[REG_ARROW_RIGHT]);
	assign idx_ok    = int'(item_s1.read_index) < QUEUE_DEPTH;
	assign q_s1_idx  = QW'(item_s1.queue_id);
	assign tail_addr = entry_addr(q_s1_idx, tail_s1);

	mem_wr_t           wr_req;
	mem_wr_t           mem_wr;
	logic [AW-1:0]     wr_addr;
	logic [CODE_W-1:0] wr_code;
	entry_data_t       wr_data;
	logic              ptr_upd;
	logic [SLOT_W-1:0] new_head, new_tail;
	logic              deliver;
	result_t           res_n;

	always_comb begin
		wr_req   = '0;
		wr_addr  = rd_addr_s1;
		wr_code  = code31;
		wr_data  = rd_data;
		ptr_upd  = 1'b0;
		new_head = head_s1;
		new_tail = tail_s1;
		deliver  = 1'b0;
		res_n    = '0;
		res_n.status = STAT_NONE;

		if (!q_ok_s1) begin
			// unknown queue: posts rejected, gets find nothing
			res_n.status = (item_s1.mode == MODE_POST_EVENT || item_s1.mode == MODE_POST_RAW) ?
			               STAT_REJECTED : STAT_NONE;
		end else begin
			case (item_s1.mode)
				MODE_POST_EVENT: begin
					if (code_neg || code31 == '0) begin
						res_n.status = STAT_REJECTED;
					end else if (is_mouse && same) begin
						// mouse move: new coordinates and timestamps
						wr_req.data_we = 1'b1;
						wr_data.word1  = item_s1.word1;
						wr_data.word2  = item_s1.word2;
						wr_data.word3  = item_s1.now;
						wr_data.word4  = item_s1.now;
						wr_data.sender = item_s1.sender;
						res_n.status   = STAT_MERGED;
					end else if (is_key && same && rd_data.word1 == item_s1.word1) begin
						// repeated keydown: bump repeat count
						wr_req.data_we = 1'b1;
						wr_data.word2  = item_s1.word2;
						wr_data.word3  = item_s1.now;
						wr_data.word4  = rd_data.word4 + 64'd1;
						wr_data.sender = item_s1.sender;
						res_n.status   = STAT_MERGED;
					end else if (!is_key && is_arrow && same) begin
						// repeated control-arrow
						wr_req.data_we = 1'b1;
						wr_data.word3  = item_s1.now;
						wr_data.word4  = rd_data.word4 + 64'd1;
						wr_data.sender = item_s1.sender;
						res_n.status   = STAT_MERGED;
					end else begin
						wr_req.code_we = 1'b1;
						wr_req.data_we = 1'b1;
						wr_addr        = tail_addr;
						wr_data.word1  = item_s1.word1;
						wr_data.word2  = item_s1.word2;
						wr_data.word3  = item_s1.now;
						wr_data.word4  = item_s1.now;
						wr_data.sender = item_s1.sender;
						ptr_upd        = 1'b1;
						new_tail       = next_slot(tail_s1);
						res_n.status   = STAT_APPENDED;
					end
				end
				MODE_POST_RAW: begin
					if (code_neg) begin
						res_n.status = STAT_REJECTED;
					end else begin
						wr_req.code_we = 1'b1;
						wr_req.data_we = 1'b1;
						wr_addr        = tail_addr;
						wr_data.word1  = item_s1.word1;
						wr_data.word2  = item_s1.word2;
						wr_data.word3  = item_s1.word3;
						wr_data.word4  = item_s1.word4;
						wr_data.sender = item_s1.sender;
						ptr_upd        = 1'b1;
						new_tail       = next_slot(tail_s1);
						res_n.status   = STAT_APPENDED;
					end
				end
				MODE_GET_HEAD: begin
					deliver  = (rd_code != '0);
					ptr_upd  = 1'b1;
					new_head = next_slot(head_s1);
				end
				default: begin
					// indexed get; out-of-range index only moves the pointers
					deliver = idx_ok && (rd_code != '0);
					ptr_upd = 1'b1;
					if (item_s1.restart) begin
						new_head = '0;
						new_tail = '0;
					end else begin
						new_head = next_slot(idx_ok ? SLOT_W'(item_s1.read_index) : head_s1);
					end
				end
			endcase
		end

		if (deliver) begin
			// empty the slot; payload words are dead once code is zero
			wr_req.code_we   = 1'b1;
			wr_addr          = rd_addr_s1;
			wr_code          = '0;
			res_n.status     = STAT_DELIVERED;
			res_n.out_code   = rd_code;
			res_n.out_word1  = rd_data.word1;
			res_n.out_word2  = rd_data.word2;
			res_n.out_word3  = rd_data.word3;
			res_n.out_word4  = rd_data.word4;
			res_n.out_sender = rd_data.sender;
			res_n.out_queue  = item_s1.queue_id;
			res_n.read_time  = item_s1.now;
		end
	end

	assign mem_wr.code_we = exec && wr_req.code_we;
	assign mem_wr.data_we = exec && wr_req.data_we;

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (exec)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec)
			result <= res_n;
	end

	// ---------------- storage ----------------
	cerq_entry_mem #(
		.DEPTH (N_ENTRIES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && q_ok),
		.rd_addr (rd_addr),
		.rd_code (rd_code),
		.rd_data (rd_data),
		.wr      (mem_wr),
		.wr_addr (wr_addr),
		.wr_code (wr_code),
		.wr_data (wr_data),
		.busy    (clr_busy)
	);

	cerq_ptr_file #(
		.NUM_QUEUES (NUM_QUEUES),
		.SLOT_W     (SLOT_W),
		.QW         (QW)
	) u_ptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_q    (ptr_rd_q),
		.rd_head (ptr_head),
		.rd_tail (ptr_tail),
		.we      (exec && ptr_upd),
		.wr_q    (q_s1_idx),
		.wr_head (new_head),
		.wr_tail (new_tail)
	);

endmodule

// File: verif/coalescing_event_ring_queue_core_test.sv
// coalescing_event_ring_queue_core_test: self-checking bench for the coalescing ring queue.
// Directed table plus weighted random requests, scored against a built-in ring predictor.
// Depends on cerq_pkg and coalescing_event_ring_queue_core.
`timescale 1ns / 1ps

module coalescing_event_ring_queue_core_test;
	import cerq_pkg::*;

	localparam int NUM_QUEUES  = 16;
	localparam int QUEUE_DEPTH = 32;
	localparam int N_ENTRIES   = NUM_QUEUES * QUEUE_DEPTH;
	localparam int LONG_HOLD   = 300;        // receiver back-pressure stretch, cycles
	localparam int DRAIN_WAIT  = 4;          // slack after the last result so the pipeline goes quiet
	localparam int LIMIT_NS    = 1_000_000;
	localparam logic [63:0] ONES = '1;

	// directed table row: the expected status is typed in only where it is obvious
	typedef struct {
		item_t   rq;
		bit      fixed;
		result_t want;
	} row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// predictor copy of the rings and the merge codes
	logic [31:0] ring_code [N_ENTRIES] = '{default: '0};
	logic [63:0] ring_w1   [N_ENTRIES] = '{default: '0};
	logic [63:0] ring_w2   [N_ENTRIES] = '{default: '0};
	logic [63:0] ring_w3   [N_ENTRIES] = '{default: '0};
	logic [63:0] ring_w4   [N_ENTRIES] = '{default: '0};
	logic [15:0] ring_snd  [N_ENTRIES] = '{default: '0};
	int          head_at   [NUM_QUEUES] = '{default: 0};
	int          tail_at   [NUM_QUEUES] = '{default: 0};
	logic [30:0] codes     [NUM_REGS]   = '{default: '0};

	result_t due_results [$];   // one expected result per accepted request, in order
	row_t    plan [$];
	int      errors       = 0;
	int      tx_idle_pct  = 0;
	int      rx_stall_pct = 0;
	logic    hold_req     = 1'b0;
	logic    hold_done    = 1'b0;
	int      hold_left    = 0;
	logic [63:0] tick     = '0;
	item_t   prev_event;
	bit      have_prev    = 1'b0;

	coalescing_event_ring_queue_core #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #1 clk = ~clk;

	initial begin
		#LIMIT_NS;
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int advance(int s);
		return (s + 1 >= QUEUE_DEPTH) ? 0 : s + 1;
	endfunction

	function automatic void push_entry(int q, logic [31:0] c, logic [15:0] snd,
			logic [63:0] w1, logic [63:0] w2, logic [63:0] w3, logic [63:0] w4);
		int e;
		e = q * QUEUE_DEPTH + tail_at[q];
		ring_code[e] = c;
		ring_w1[e]   = w1;
		ring_w2[e]   = w2;
		ring_w3[e]   = w3;
		ring_w4[e]   = w4;
		ring_snd[e]  = snd;
		tail_at[q]   = advance(tail_at[q]);
	endfunction

	// Read at the head slot; a delivered entry is cleared. Head is moved by the caller.
	function automatic void take_head(int q, logic [63:0] now, inout result_t r);
		int e;
		e = q * QUEUE_DEPTH + head_at[q];
		if (ring_code[e] == '0 || ring_code[e][31]) begin
			r.status = STAT_NONE;
			return;
		end
		r.status     = STAT_DELIVERED;
		r.out_code   = ring_code[e][30:0];
		r.out_word1  = ring_w1[e];
		r.out_word2  = ring_w2[e];
		r.out_word3  = ring_w3[e];
		r.out_word4  = ring_w4[e];
		r.out_sender = ring_snd[e];
		r.out_queue  = 4'(q);
		r.read_time  = now;
		ring_code[e] = '0;
		ring_w1[e]   = '0;
		ring_w2[e]   = '0;
		ring_w3[e]   = '0;
		ring_w4[e]   = '0;
		ring_snd[e]  = '0;
	endfunction

	// Event post: merge into the entry just behind the tail when the code allows it.
	function automatic logic [2:0] post_or_merge(int q, logic [31:0] c, item_t it);
		int  tail_e;
		bit  same;
		tail_e = q * QUEUE_DEPTH + (tail_at[q] + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
		same   = (ring_code[tail_e] == c);
		if (c == codes[REG_MOUSE_MOVE] && same) begin
			// mouse move: latest coordinates win
			ring_w1[tail_e]  = it.word1;
			ring_w2[tail_e]  = it.word2;
			ring_w3[tail_e]  = it.now;
			ring_w4[tail_e]  = it.now;
			ring_snd[tail_e] = it.sender;
			return STAT_MERGED;
		end
		if (c == codes[REG_KEY_DOWN]) begin
			// keydown only merges on the same key
			if (same && ring_w1[tail_e] == it.word1) begin
				ring_w2[tail_e]  = it.word2;
				ring_w3[tail_e]  = it.now;
				ring_w4[tail_e]  = ring_w4[tail_e] + 64'd1;
				ring_snd[tail_e] = it.sender;
				return STAT_MERGED;
			end
		end else if (c == codes[REG_ARROW_UP] || c == codes[REG_ARROW_DOWN] ||
				c == codes[REG_ARROW_LEFT] || c == codes[REG_ARROW_RIGHT]) begin
			if (same) begin
				ring_w3[tail_e]  = it.now;
				ring_w4[tail_e]  = ring_w4[tail_e] + 64'd1;
				ring_snd[tail_e] = it.sender;
				return STAT_MERGED;
			end
		end
		push_entry(q, c, it.sender, it.word1, it.word2, it.now, it.now);
		return STAT_APPENDED;
	endfunction

	function automatic result_t ring_response(item_t it);
		result_t     r;
		int          q;
		logic [31:0] c;
		r = '0;
		q = int'(it.queue_id);
		c = it.code;
		if (q >= NUM_QUEUES) begin
			r.status = (it.mode == MODE_POST_EVENT || it.mode == MODE_POST_RAW) ?
				STAT_REJECTED : STAT_NONE;
			return r;
		end
		case (it.mode)
			MODE_POST_EVENT: begin
				if (c[31] || c == '0)
					r.status = STAT_REJECTED;
				else
					r.status = post_or_merge(q, c, it);
			end
			MODE_POST_RAW: begin
				// raw code zero is stored and later reads back as empty
				if (c[31]) begin
					r.status = STAT_REJECTED;
				end else begin
					push_entry(q, c, it.sender, it.word1, it.word2, it.word3, it.word4);
					r.status = STAT_APPENDED;
				end
			end
			MODE_GET_HEAD: begin
				take_head(q, it.now, r);
				head_at[q] = advance(head_at[q]);
			end
			default: begin
				if (int'(it.read_index) < QUEUE_DEPTH) begin
					head_at[q] = int'(it.read_index);
					take_head(q, it.now, r);
				end else begin
					r.status = STAT_NONE;
				end
				if (it.restart) begin
					head_at[q] = 0;
					tail_at[q] = 0;
				end else begin
					head_at[q] = advance(head_at[q]);
				end
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void field_match(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	task automatic compare_result(input result_t got);
		result_t want;
		if (due_results.size() == 0) begin
			$display("%0t: unexpected result transaction, expected none, got %h", $time, got);
			errors++;
			return;
		end
		want = due_results.pop_front();
		field_match("status",     64'(want.status),     64'(got.status));
		field_match("out_code",   64'(want.out_code),   64'(got.out_code));
		field_match("out_word1",  want.out_word1,       got.out_word1);
		field_match("out_word2",  want.out_word2,       got.out_word2);
		field_match("out_word3",  want.out_word3,       got.out_word3);
		field_match("out_word4",  want.out_word4,       got.out_word4);
		field_match("out_sender", 64'(want.out_sender), 64'(got.out_sender));
		field_match("out_queue",  64'(want.out_queue),  64'(got.out_queue));
		field_match("read_time",  want.read_time,       got.read_time);
	endtask

	// sampled at the edge, so both sides see pre-edge values
	always @(posedge clk)
		if (arst_n && result_valid && result_ready)
			compare_result(result);

	// Receiver: random stalls per phase; a hold request forces one long stretch of
	// back-pressure so a result waits and the block drops item_ready.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic item_t req(logic [1:0] m, logic [3:0] q, logic [15:0] s,
			logic [31:0] c, logic [63:0] w1, logic [63:0] w2, logic [63:0] w3,
			logic [63:0] w4, logic [63:0] now, logic [4:0] idx, logic rst);
		item_t it;
		it.mode       = m;
		it.queue_id   = q;
		it.sender     = s;
		it.code       = c;
		it.word1      = w1;
		it.word2      = w2;
		it.word3      = w3;
		it.word4      = w4;
		it.now        = now;
		it.read_index = idx;
		it.restart    = rst;
		return it;
	endfunction

	function automatic void add_row(item_t rq, bit fixed, logic [2:0] st = STAT_NONE);
		row_t rw;
		rw.rq          = rq;
		rw.fixed       = fixed;
		rw.want        = '0;
		rw.want.status = st;
		plan.push_back(rw);
	endfunction

	// configured codes half the time so merges happen, plus small, zero, negative and wild codes
	function automatic logic [31:0] pick_code();
		int sel;
		sel = $urandom_range(19);
		if (sel < 10)
			return {1'b0, codes[$urandom_range(NUM_REGS - 1)]};
		else if (sel < 14)
			return $urandom_range(20, 1);
		else if (sel == 14)
			return '0;
		else if (sel < 17)
			return {1'b1, 31'($urandom)};
		return $urandom;
	endfunction

	function automatic item_t random_request();
		item_t it;
		int    sel;
		sel = $urandom_range(9);
		if (sel < 4)
			it.mode = MODE_POST_EVENT;
		else if (sel < 6)
			it.mode = MODE_POST_RAW;
		else if (sel < 9)
			it.mode = MODE_GET_HEAD;
		else
			it.mode = MODE_GET_INDEX;
		// a few busy queues keep rings deep enough to wrap and merge
		it.queue_id   = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
			4'($urandom_range(2));
		it.sender     = 16'($urandom);
		it.code       = pick_code();
		it.word1      = ($urandom_range(1) == 0) ? 64'($urandom_range(3)) : {$urandom, $urandom};
		it.word2      = {$urandom, $urandom};
		it.word3      = {$urandom, $urandom};
		it.word4      = {$urandom, $urandom};
		tick          = tick + 64'($urandom_range(50));
		it.now        = ($urandom_range(15) == 0) ? {$urandom, $urandom} : tick;
		it.read_index = 5'($urandom);
		it.restart    = ($urandom_range(7) == 0);
		// repeat the previous event often: same ring, code and usually key
		if (it.mode == MODE_POST_EVENT) begin
			if (have_prev && $urandom_range(9) < 5) begin
				it.queue_id = prev_event.queue_id;
				it.code     = prev_event.code;
				if ($urandom_range(3) != 0)
					it.word1 = prev_event.word1;
			end
			prev_event = it;
			have_prev  = 1'b1;
		end
		return it;
	endfunction

	// Offer one request after a random idle gap; returns at the accepting edge.
	// valid is left high so a back-to-back request keeps it up without a glitch.
	task automatic send_item(input item_t rq);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= rq;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	// Register writes: one per cycle, only while the block has nothing in flight.
	task automatic load_codes(input logic [30:0] mouse, input logic [30:0] key,
			input logic [30:0] up, input logic [30:0] down, input logic [30:0] left,
			input logic [30:0] right);
		logic [30:0] v [NUM_REGS];
		v[REG_MOUSE_MOVE]  = mouse;
		v[REG_KEY_DOWN]    = key;
		v[REG_ARROW_UP]    = up;
		v[REG_ARROW_DOWN]  = down;
		v[REG_ARROW_LEFT]  = left;
		v[REG_ARROW_RIGHT] = right;
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= v[i];
			codes[i]  = v[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// wait until every expected result is in, then let the pipeline go quiet
	task automatic settle();
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
			input bit with_hold);
		item_t rq;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		for (int n = 0; n < n_items; n++) begin
			rq = random_request();
			send_item(rq);
			due_results.push_back(ring_response(rq));
			if (with_hold && n == 40)
				hold_req <= 1'b1;
		end
		item_valid <= 1'b0;
	endtask

	initial begin
		result_t predicted;

		// Directed table, written for merge codes 5 / 7 / 10..13.
		// Empty ring read, all rejection paths, then every merge kind on ring 0.
		add_row(req(MODE_GET_HEAD, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, STAT_NONE);
		add_row(req(MODE_POST_EVENT, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1, STAT_REJECTED);
		add_row(req(MODE_POST_EVENT, 0, 0, -1, 0, 0, 0, 0, 1, 0, 0), 1, STAT_REJECTED);
		add_row(req(MODE_POST_EVENT, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 1, 0, 0),
			1, STAT_REJECTED);
		add_row(req(MODE_POST_RAW, 0, 0, -5, 0, 0, 0, 0, 1, 0, 0), 1, STAT_REJECTED);
		add_row(req(MODE_POST_EVENT, 0, 16'hFFFF, 5, 0, ONES, 0, 0, 0, 0, 0),
			1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 1, 5, ONES, 0, 0, 0, ONES, 0, 0), 1, STAT_MERGED);
		add_row(req(MODE_POST_EVENT, 0, 2, 7, 'h41, 1, 0, 0, 3, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 3, 7, 'h41, 2, 0, 0, 4, 0, 0), 1, STAT_MERGED);
		// keydown with another key starts a new entry
		add_row(req(MODE_POST_EVENT, 0, 4, 7, 'h42, 3, 0, 0, 5, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 5, 10, 1, 1, 0, 0, 6, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 6, 10, 2, 2, 0, 0, 7, 0, 0), 1, STAT_MERGED);
		add_row(req(MODE_POST_EVENT, 0, 7, 11, 1, 1, 0, 0, 8, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 8, 11, 2, 2, 0, 0, 9, 0, 0), 1, STAT_MERGED);
		add_row(req(MODE_POST_EVENT, 0, 9, 12, 1, 1, 0, 0, 10, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 10, 12, 2, 2, 0, 0, 11, 0, 0), 1, STAT_MERGED);
		add_row(req(MODE_POST_EVENT, 0, 11, 13, 1, 1, 0, 0, 12, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_POST_EVENT, 0, 12, 13, 2, 2, 0, 0, 13, 0, 0), 1, STAT_MERGED);
		add_row(req(MODE_POST_RAW, 0, 16'hFFFF, 32'h7FFF_FFFF, ONES, ONES, ONES, ONES,
			ONES, 0, 0), 1, STAT_APPENDED);
		// raw code zero lands in the ring but reads back as empty
		add_row(req(MODE_POST_RAW, 0, 13, 0, 5, 6, 7, 8, 14, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_GET_HEAD, 0, 0, 0, 0, 0, 0, 0, 100, 0, 0), 0);
		add_row(req(MODE_GET_INDEX, 0, 0, 0, 0, 0, 0, 0, 101, 8, 0), 1, STAT_NONE);
		// indexed read of the raw entry, then restart both pointers
		add_row(req(MODE_GET_INDEX, 0, 0, 0, 0, 0, 0, 0, ONES, 7, 1), 0);
		add_row(req(MODE_GET_HEAD, 0, 0, 0, 0, 0, 0, 0, 102, 0, 0), 1, STAT_NONE);
		add_row(req(MODE_POST_EVENT, 15, 16'hFFFF, 32'h7FFF_FFFF, ONES, ONES, 0, 0,
			ONES, 0, 0), 1, STAT_APPENDED);
		add_row(req(MODE_GET_INDEX, 15, 0, 0, 0, 0, 0, 0, 0, 31, 0), 0);
		add_row(req(MODE_GET_INDEX, 15, 0, 0, 0, 0, 0, 0, 200, 0, 0), 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// registers are taken during the post-reset memory sweep
		load_codes(5, 7, 10, 11, 12, 13);

		foreach (plan[i]) begin
			send_item(plan[i].rq);
			predicted = ring_response(plan[i].rq);
			due_results.push_back(plan[i].fixed ? plan[i].want : predicted);
		end

		// no idling, with one long receiver hold
		run_phase(210, 0, 0, 1);
		settle();
		// all merges disabled, sender idles
		load_codes(0, 0, 0, 0, 0, 0);
		run_phase(210, 61, 0, 0);
		settle();
		// top and bottom of the code range, receiver stalls
		load_codes(31'h7FFF_FFFF, 1, 2, 3, 4, 31'h7FFF_FFFE);
		run_phase(210, 0, 61, 0);
		settle();
		// small random codes, overlaps between registers likely
		load_codes(31'($urandom_range(8, 1)), 31'($urandom_range(8, 1)),
			31'($urandom_range(8, 1)), 31'($urandom_range(8, 1)),
			31'($urandom_range(8, 1)), 31'($urandom_range(8, 1)));
		run_phase(210, 31, 31, 0);
		settle();

		if (errors == 0 && due_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
